// ===== design/bdcd_pkg.sv =====
// ----------------------------------------------------------------------------
// bdcd_pkg
// Types and constants shared by the button debounce / click detector blocks.
// ----------------------------------------------------------------------------
package bdcd_pkg;

   // command codes of an input word
   localparam logic [1:0] CMD_TICK      = 2'd0;
   localparam logic [1:0] CMD_CLEAR_ONE = 2'd1;
   localparam logic [1:0] CMD_CLEAR_ALL = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_DEBOUNCE_COUNT    = 2'd0;
   localparam logic [1:0] CSR_HOLD_TICKS        = 2'd1;
   localparam logic [1:0] CSR_MULTI_PRESS_TICKS = 2'd2;
   localparam logic [1:0] CSR_ACTIVE_LOW        = 2'd3;

   // bit positions inside a button's sticky flag set
   localparam int FLAG_SINGLE  = 0;
   localparam int FLAG_DOUBLE  = 1;
   localparam int FLAG_TRIPLE  = 2;
   localparam int FLAG_RELEASE = 3;
   localparam int FLAG_HOLD    = 4;

   // buttons visible in the raw field and in the result word
   localparam int FIELD_BUTTONS = 4;

   typedef struct packed {
      logic [1:0] command;
      logic [3:0] raw_levels;
      logic [1:0] clear_button;
      logic [4:0] clear_mask;
   } req_word_type;

   typedef struct packed {
      logic [3:0] single_press_flags;
      logic [3:0] double_press_flags;
      logic [3:0] triple_press_flags;
      logic [3:0] release_flags;
      logic [3:0] hold_flags;
      logic [3:0] pressed_levels;
   } rsp_word_type;

   typedef struct packed {
      logic [7:0]  debounce_count;
      logic [15:0] hold_ticks;
      logic [15:0] multi_press_ticks;
   } lane_cfg_type;

   typedef struct packed {
      logic       tick;
      logic       level;
      logic       clear_flags;
      logic [4:0] clear_mask;
   } lane_cmd_type;

   typedef struct packed {
      logic [4:0] flags;
      logic       pressed;
   } lane_status_type;

endpackage

// ===== design/bdcd_lane.sv =====
// ----------------------------------------------------------------------------
// bdcd_lane
// Per-button core: debounce, hold and multi-press timers, sticky flags.
// ----------------------------------------------------------------------------
module bdcd_lane (
   input  logic                      clock,
   input  logic                      reset,
   input  bdcd_pkg::lane_cfg_type    cfg,
   input  bdcd_pkg::lane_cmd_type    cmd,
   output bdcd_pkg::lane_status_type status_next
);

   logic        prev_ff,     prev_in;
   logic [7:0]  run_ff,      run_in;
   logic        pressed_ff,  pressed_in;
   logic        awaiting_ff, awaiting_in;
   logic [2:0]  tally_ff,    tally_in;
   logic [15:0] hold_cnt_ff, hold_cnt_in;
   logic        hold_run_ff, hold_run_in;
   logic        hold_exp_ff, hold_exp_in;
   logic [15:0] win_cnt_ff,  win_cnt_in;
   logic        win_run_ff,  win_run_in;
   logic        win_exp_ff,  win_exp_in;
   logic [4:0]  flags_ff,    flags_in;

   always_comb begin
      logic [7:0] need;
      logic [8:0] run_sum;
      logic [8:0] run_cap;

      prev_in     = prev_ff;
      run_in      = run_ff;
      pressed_in  = pressed_ff;
      awaiting_in = awaiting_ff;
      tally_in    = tally_ff;
      hold_cnt_in = hold_cnt_ff;
      hold_run_in = hold_run_ff;
      hold_exp_in = hold_exp_ff;
      win_cnt_in  = win_cnt_ff;
      win_run_in  = win_run_ff;
      win_exp_in  = win_exp_ff;
      flags_in    = flags_ff;

      // a zero debounce count acts as one
      need    = (cfg.debounce_count == 8'd0) ? 8'd1 : cfg.debounce_count;
      run_sum = {1'b0, run_ff} + 9'd1;
      run_cap = {1'b0, need} + 9'd1;
      if (run_sum > run_cap) begin
         run_sum = run_cap;
      end
      if (run_sum > 9'd255) begin
         run_sum = 9'd255;
      end

      if (cmd.tick) begin
         // consume last tick's hold expiry, then advance
         if (hold_exp_ff) begin
            hold_exp_in = 1'b0;
            flags_in[bdcd_pkg::FLAG_HOLD] = 1'b1;
         end
         if (hold_run_ff) begin
            if (hold_cnt_ff <= 16'd1) begin
               hold_cnt_in = 16'd0;
               hold_exp_in = 1'b1;
               hold_run_in = 1'b0;
            end else begin
               hold_cnt_in = hold_cnt_ff - 16'd1;
            end
         end

         // judge the press count once the window has closed
         if (win_exp_ff) begin
            win_exp_in = 1'b0;
            case (tally_ff)
               3'd1: begin
                  flags_in[bdcd_pkg::FLAG_SINGLE] = 1'b1;
                  if (!pressed_ff) begin
                     flags_in[bdcd_pkg::FLAG_RELEASE] = 1'b1;
                  end else begin
                     awaiting_in = 1'b1;
                  end
               end
               3'd2: flags_in[bdcd_pkg::FLAG_DOUBLE] = 1'b1;
               3'd3: flags_in[bdcd_pkg::FLAG_TRIPLE] = 1'b1;
               default: ;
            endcase
            tally_in = 3'd0;
         end
         if (win_run_ff) begin
            if (win_cnt_ff <= 16'd1) begin
               win_cnt_in = 16'd0;
               win_exp_in = 1'b1;
               win_run_in = 1'b0;
            end else begin
               win_cnt_in = win_cnt_ff - 16'd1;
            end
         end

         // debounce the new sample
         if (cmd.level == prev_ff) begin
            run_in = run_sum[7:0];
            if (run_sum == {1'b0, need} && run_ff < need) begin
               if (cmd.level) begin
                  pressed_in  = 1'b1;
                  hold_cnt_in = cfg.hold_ticks;
                  hold_run_in = 1'b1;
                  hold_exp_in = 1'b0;
                  win_cnt_in  = cfg.multi_press_ticks;
                  win_run_in  = 1'b1;
                  win_exp_in  = 1'b0;
                  if (tally_in != 3'd7) begin
                     tally_in = tally_in + 3'd1;
                  end
                  awaiting_in = 1'b0;
               end else begin
                  pressed_in = 1'b0;
                  if (awaiting_in) begin
                     awaiting_in = 1'b0;
                     flags_in[bdcd_pkg::FLAG_RELEASE] = 1'b1;
                  end
                  hold_run_in = 1'b0;
               end
            end
         end else begin
            run_in = 8'd0;
         end
         prev_in = cmd.level;
      end

      if (cmd.clear_flags) begin
         flags_in = flags_in & ~cmd.clear_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff     <= 1'b0;
         run_ff      <= 8'd0;
         pressed_ff  <= 1'b0;
         awaiting_ff <= 1'b0;
         tally_ff    <= 3'd0;
         hold_cnt_ff <= 16'd0;
         hold_run_ff <= 1'b0;
         hold_exp_ff <= 1'b0;
         win_cnt_ff  <= 16'd0;
         win_run_ff  <= 1'b0;
         win_exp_ff  <= 1'b0;
         flags_ff    <= 5'd0;
      end else begin
         prev_ff     <= prev_in;
         run_ff      <= run_in;
         pressed_ff  <= pressed_in;
         awaiting_ff <= awaiting_in;
         tally_ff    <= tally_in;
         hold_cnt_ff <= hold_cnt_in;
         hold_run_ff <= hold_run_in;
         hold_exp_ff <= hold_exp_in;
         win_cnt_ff  <= win_cnt_in;
         win_run_ff  <= win_run_in;
         win_exp_ff  <= win_exp_in;
         flags_ff    <= flags_in;
      end
   end

   assign status_next.flags   = flags_in;
   assign status_next.pressed = pressed_in;

   a_hold_run_exp_excl : assert property (@(posedge clock) disable iff (reset)
      !(hold_run_ff && hold_exp_ff))
      else $error("hold timer both running and expired");

   a_tally_needs_window : assert property (@(posedge clock) disable iff (reset)
      (tally_ff != 3'd0) |-> (win_run_ff || win_exp_ff))
      else $error("press tally pending without an open window");

   a_awaiting_while_pressed : assert property (@(posedge clock) disable iff (reset)
      awaiting_ff |-> pressed_ff)
      else $error("awaiting release while button not pressed");

endmodule

// ===== design/bdcd_merge.sv =====
// ----------------------------------------------------------------------------
// bdcd_merge
// Gathers the lanes' flags into one result word and buffers it two deep.
// ----------------------------------------------------------------------------
module bdcd_merge #(
   parameter int NUM_BUTTONS = 4
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        push,
   input  bdcd_pkg::lane_status_type [NUM_BUTTONS-1:0] lane_next,
   output logic                                        full,
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output bdcd_pkg::rsp_word_type                      rsp_word
);

   logic [3:0] single_v, double_v, triple_v, release_v, hold_v, pressed_v;
   bdcd_pkg::rsp_word_type word;

   for (genvar b = 0; b < bdcd_pkg::FIELD_BUTTONS; b++) begin : g_bit
      if (b < NUM_BUTTONS) begin : g_lane
         assign single_v[b]  = lane_next[b].flags[bdcd_pkg::FLAG_SINGLE];
         assign double_v[b]  = lane_next[b].flags[bdcd_pkg::FLAG_DOUBLE];
         assign triple_v[b]  = lane_next[b].flags[bdcd_pkg::FLAG_TRIPLE];
         assign release_v[b] = lane_next[b].flags[bdcd_pkg::FLAG_RELEASE];
         assign hold_v[b]    = lane_next[b].flags[bdcd_pkg::FLAG_HOLD];
         assign pressed_v[b] = lane_next[b].pressed;
      end else begin : g_none
         assign single_v[b]  = 1'b0;
         assign double_v[b]  = 1'b0;
         assign triple_v[b]  = 1'b0;
         assign release_v[b] = 1'b0;
         assign hold_v[b]    = 1'b0;
         assign pressed_v[b] = 1'b0;
      end
   end

   assign word.single_press_flags = single_v;
   assign word.double_press_flags = double_v;
   assign word.triple_press_flags = triple_v;
   assign word.release_flags      = release_v;
   assign word.hold_flags         = hold_v;
   assign word.pressed_levels     = pressed_v;

   logic                   out_valid_ff,  out_valid_in;
   bdcd_pkg::rsp_word_type out_word_ff,   out_word_in;
   logic                   skid_valid_ff, skid_valid_in;
   bdcd_pkg::rsp_word_type skid_word_ff,  skid_word_in;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_word_in   = out_word_ff;
      skid_valid_in = skid_valid_ff;
      skid_word_in  = skid_word_ff;
      if (!out_valid_ff || !rsp_stall) begin
         // output slot frees up: drain the skid first, else take the new word
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_word_in   = skid_word_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_word_in  = word;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_word_in  = word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word held while output slot empty");

   a_no_push_when_full : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !push)
      else $error("word pushed into a full buffer");

   a_rsp_held_while_stalled : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_word)))
      else $error("result word changed while stalled");

endmodule

// ===== design/button_debounce_click_detector_unit.sv =====
// ----------------------------------------------------------------------------
// button_debounce_click_detector_unit
// Debounces NUM_BUTTONS buttons and reports single, double and triple
// presses, releases after a single press, and long holds as sticky flags.
// Every accepted word (tick, clear one button, clear all) gives exactly one
// result word showing the flags and debounced levels after that command.
// One word is accepted per clock while req_stall is low; all buttons update in
// parallel, and each result is registered in the output buffer for the rsp side.
// A two-entry output buffer sits between the sides, so req_stall rises only
// once two results are waiting; configuration writes are always ready.
// ----------------------------------------------------------------------------
module button_debounce_click_detector_unit #(
   parameter int NUM_BUTTONS = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  bdcd_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output bdcd_pkg::rsp_word_type rsp_word,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [15:0]            csr_wdata
);

   logic [7:0]  debounce_ff, debounce_in;
   logic [15:0] hold_ff,     hold_in;
   logic [15:0] window_ff,   window_in;
   logic        act_low_ff,  act_low_in;

   assign csr_ready = 1'b1;

   always_comb begin
      debounce_in = debounce_ff;
      hold_in     = hold_ff;
      window_in   = window_ff;
      act_low_in  = act_low_ff;
      if (csr_valid) begin
         case (csr_index)
            bdcd_pkg::CSR_DEBOUNCE_COUNT:    debounce_in = csr_wdata[7:0];
            bdcd_pkg::CSR_HOLD_TICKS:        hold_in     = csr_wdata;
            bdcd_pkg::CSR_MULTI_PRESS_TICKS: window_in   = csr_wdata;
            bdcd_pkg::CSR_ACTIVE_LOW:        act_low_in  = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= 8'd3;
         hold_ff     <= 16'd100;
         window_ff   <= 16'd30;
         act_low_ff  <= 1'b1;
      end else begin
         debounce_ff <= debounce_in;
         hold_ff     <= hold_in;
         window_ff   <= window_in;
         act_low_ff  <= act_low_in;
      end
   end

   bdcd_pkg::lane_cfg_type lane_cfg;
   assign lane_cfg.debounce_count    = debounce_ff;
   assign lane_cfg.hold_ticks        = hold_ff;
   assign lane_cfg.multi_press_ticks = window_ff;

   logic accept;
   logic full;
   logic is_tick, is_clear_one, is_clear_all;

   assign req_stall    = full;
   assign accept       = req_valid && !full;
   assign is_tick      = accept && (req_word.command == bdcd_pkg::CMD_TICK);
   assign is_clear_one = accept && (req_word.command == bdcd_pkg::CMD_CLEAR_ONE);
   assign is_clear_all = accept && (req_word.command == bdcd_pkg::CMD_CLEAR_ALL);

   bdcd_pkg::lane_status_type [NUM_BUTTONS-1:0] lane_next;

   for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
      bdcd_pkg::lane_cmd_type cmd;
      logic                   raw_bit;

      // buttons beyond the raw field sample as zero
      if (b < bdcd_pkg::FIELD_BUTTONS) begin : g_raw
         assign raw_bit = req_word.raw_levels[b];
      end else begin : g_zero
         assign raw_bit = 1'b0;
      end

      assign cmd.tick        = is_tick;
      assign cmd.level       = raw_bit ^ act_low_ff;
      assign cmd.clear_flags = is_clear_all ||
                               (is_clear_one && (int'(req_word.clear_button) == b));
      assign cmd.clear_mask  = is_clear_all ? 5'h1f : req_word.clear_mask;

      bdcd_lane u_lane (
         .clock       (clock),
         .reset       (reset),
         .cfg         (lane_cfg),
         .cmd         (cmd),
         .status_next (lane_next[b])
      );
   end

   bdcd_merge #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .lane_next (lane_next),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule
